[rtl/core/spfrm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Split pointer frame ring manager package
// Shared types, widths and constants for the frame ring manager.
// ----------------------------------------------------------------------------
package spfrm_pkg;

   localparam int RING_LOG2_DEFAULT = 7;

   localparam int CMD_W    = 3;
   localparam int FRAMES_W = 8;
   localparam int OFFSET_W = 17;
   localparam int BASE_W   = 16;
   localparam int LOG2_W   = 3;
   localparam int LEVEL_W  = 7;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam int MF_FRAMES = 16;

   localparam logic [LOG2_W-1:0] LENGTH_LOG2_RESET = 3'd7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_OFFSET = 1'b0,
      CSR_LENGTH_LOG2 = 1'b1
   } csr_idx_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_FRAME_WRITE = 3'd0,
      CMD_FRAME_READ  = 3'd1,
      CMD_MF_PREPARE  = 3'd2,
      CMD_MF_COMMIT   = 3'd3,
      CMD_MF_PEEK     = 3'd4,
      CMD_MF_DISCARD  = 3'd5,
      CMD_EMPTY       = 3'd6,
      CMD_NONE        = 3'd7
   } cmd_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
   } ctl_type;

endpackage
`default_nettype wire

[rtl/core/spfrm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame ring manager controller
// Sequences each request through load, execute and result hand-off.
// ----------------------------------------------------------------------------
module spfrm_ctrl
   import spfrm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output ctl_type      ctl
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // A new request may enter while the previous result is being taken.
   assign req_tready = (state_ff == ST_IDLE) || ((state_ff == ST_DONE) && rsp_tready);
   assign rsp_tvalid = (state_ff == ST_DONE);
   assign accept     = req_tvalid && req_tready;
   assign ctl.load   = accept;
   assign ctl.exec   = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (accept) state_in = ST_EXEC;
            else if (rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

[rtl/core/spfrm_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame ring manager datapath
// Ring pointers, configuration registers and the result register.
// ----------------------------------------------------------------------------
module spfrm_dpath
   import spfrm_pkg::*;
#(
   parameter int MAX_RING_LOG2 = RING_LOG2_DEFAULT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   input  wire ctl_type               ctl,
   input  wire logic [CMD_W-1:0]      cmd,
   input  wire logic [FRAMES_W-1:0]   frame_limit,
   output logic [OFFSET_W-1:0]        offset,
   output logic [FRAMES_W-1:0]        frames_granted,
   output logic                       success,
   output logic [LEVEL_W-1:0]         allocated_level,
   output logic [LEVEL_W-1:0]         valid_level,
   output logic [LEVEL_W-1:0]         unseen_level,
   output logic [LEVEL_W-1:0]         free_level
);

   localparam int PW = MAX_RING_LOG2;
   localparam int LW = $clog2(PW + 1);
   localparam int GW = (PW + 1 > FRAMES_W) ? PW + 1 : FRAMES_W;

   logic [BASE_W-1:0]   base_ff;
   logic [LOG2_W-1:0]   log2_ff;
   logic [PW-1:0]       wc_ff, wa_ff, rd_ff, rp_ff;
   logic [PW-1:0]       wc_in, wa_in, rd_in, rp_in;
   cmd_type             cmd_ff;
   logic [FRAMES_W-1:0] max_ff;

   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [FRAMES_W-1:0] grant_ff, grant_in;
   logic                ok_ff, ok_in;
   logic [LEVEL_W-1:0]  alloc_lvl_ff, valid_lvl_ff, unseen_lvl_ff, free_lvl_ff;

   logic [LW-1:0]       sat_log2;
   logic [PW:0]         mask_full;
   logic [PW-1:0]       mask;
   logic [PW-1:0]       wc, wa, rd, rp;
   logic [PW-1:0]       free_av, unseen_av;
   logic [PW:0]         wr_to_end, rd_to_end;
   logic [GW-1:0]       wr_clip, rd_clip, wr_grant, rd_grant;
   logic [PW-1:0]       mf_step, align;

   // Ring length saturates at the largest ring the pointers can address.
   assign sat_log2  = (32'(log2_ff) > PW) ? LW'(PW) : LW'(log2_ff);
   assign mask_full = ((PW + 1)'(1) << sat_log2) - (PW + 1)'(1);
   assign mask      = mask_full[PW-1:0];
   assign mf_step   = PW'(MF_FRAMES);
   assign align     = ~PW'(MF_FRAMES - 1);

   // Pointers are reduced to the current ring before use, as length may change.
   assign wc = wc_ff & mask;
   assign wa = wa_ff & mask;
   assign rd = rd_ff & mask;
   assign rp = rp_ff & mask;

   assign free_av   = (rd - wa - PW'(1)) & mask;
   assign unseen_av = (wc - rp) & mask;

   assign wr_to_end = {1'b0, mask} - {1'b0, wc} + (PW + 1)'(1);
   assign rd_to_end = {1'b0, mask} - {1'b0, rp} + (PW + 1)'(1);

   assign wr_clip  = (GW'(max_ff) > GW'(wr_to_end)) ? GW'(wr_to_end) : GW'(max_ff);
   assign wr_grant = (wr_clip > GW'(free_av)) ? GW'(free_av) : wr_clip;
   assign rd_clip  = (GW'(max_ff) > GW'(rd_to_end)) ? GW'(rd_to_end) : GW'(max_ff);
   assign rd_grant = (rd_clip > GW'(unseen_av)) ? GW'(unseen_av) : rd_clip;

   always_comb begin
      wc_in     = wc;
      wa_in     = wa;
      rd_in     = rd;
      rp_in     = rp;
      offset_in = '0;
      grant_in  = '0;
      ok_in     = 1'b1;
      unique case (cmd_ff)
         CMD_FRAME_WRITE: begin
            grant_in  = FRAMES_W'(wr_grant);
            offset_in = OFFSET_W'(base_ff) + OFFSET_W'(wc);
            wc_in     = (wc + PW'(wr_grant)) & mask;
            wa_in     = wc_in;
         end
         CMD_FRAME_READ: begin
            grant_in  = FRAMES_W'(rd_grant);
            offset_in = OFFSET_W'(base_ff) + OFFSET_W'(rp);
            rp_in     = (rp + PW'(rd_grant)) & mask;
            rd_in     = rp_in;
         end
         CMD_MF_PREPARE: begin
            if (32'(free_av) < MF_FRAMES) begin
               ok_in = 1'b0;
            end else begin
               offset_in = OFFSET_W'(base_ff) + OFFSET_W'(wa);
               wa_in     = (wa + mf_step) & mask;
            end
         end
         CMD_MF_COMMIT: begin
            wc_in = (wc + mf_step) & mask;
         end
         CMD_MF_PEEK: begin
            if (32'(unseen_av) < MF_FRAMES) begin
               ok_in = 1'b0;
            end else begin
               offset_in = OFFSET_W'(base_ff) + OFFSET_W'(rp);
               rp_in     = (rp + mf_step) & mask;
            end
         end
         CMD_MF_DISCARD: begin
            rd_in = (rd + mf_step) & mask;
         end
         CMD_EMPTY: begin
            rd_in = wc & align & mask;
            rp_in = wc & align & mask;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         log2_ff <= LENGTH_LOG2_RESET;
         wc_ff   <= '0;
         wa_ff   <= '0;
         rd_ff   <= '0;
         rp_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_idx_type'(csr_index))
               CSR_BASE_OFFSET: base_ff <= BASE_W'(csr_wr_data);
               CSR_LENGTH_LOG2: log2_ff <= LOG2_W'(csr_wr_data);
               default: begin
               end
            endcase
         end
         if (ctl.exec) begin
            wc_ff <= wc_in;
            wa_ff <= wa_in;
            rd_ff <= rd_in;
            rp_ff <= rp_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= cmd_type'(cmd);
         max_ff <= frame_limit;
      end
      if (ctl.exec) begin
         offset_ff     <= offset_in;
         grant_ff      <= grant_in;
         ok_ff         <= ok_in;
         alloc_lvl_ff  <= LEVEL_W'((wa_in - rd_in) & mask);
         valid_lvl_ff  <= LEVEL_W'((wc_in - rd_in) & mask);
         unseen_lvl_ff <= LEVEL_W'((wc_in - rp_in) & mask);
         free_lvl_ff   <= LEVEL_W'((rd_in - wa_in - PW'(1)) & mask);
      end
   end

   assign offset          = offset_ff;
   assign frames_granted  = grant_ff;
   assign success         = ok_ff;
   assign allocated_level = alloc_lvl_ff;
   assign valid_level     = valid_lvl_ff;
   assign unseen_level    = unseen_lvl_ff;
   assign free_level      = free_lvl_ff;

endmodule
`default_nettype wire

[rtl/core/split_pointer_frame_ring_manager_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Split pointer frame ring manager
// Frame ring with committed/allocated write and discarded/peeked read pointers.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  req_*     in         one command request: cmd, frame_limit
//  rsp_*     out        one result per request: offset, grant, success, levels
//  csr_*     in         register writes: base_offset, length_log2
//
//  A request is registered at its accepting edge and the pointer datapath
//  executes it in the following cycle, registering its result at the end
//  of that cycle. A request is accepted in the cycle its predecessor's
//  result is taken, so a new request is not accepted while the previous
//  one is still executing.
//  A held result (rsp_tready low) stalls the request side. Synchronous reset
//  clears the pointers, sets base_offset to 0 and length_log2 to 7.
// ----------------------------------------------------------------------------
module split_pointer_frame_ring_manager_top
   import spfrm_pkg::*;
#(
   parameter int MAX_RING_LOG2 = RING_LOG2_DEFAULT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // cmd[2:0], frame_limit[10:3]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // offset[16:0], frames_granted[24:17], success[25], allocated_level[32:26],
   // valid_level[39:33], unseen_level[46:40], free_level[53:47]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   ctl_type             ctl;
   logic [OFFSET_W-1:0] offset;
   logic [FRAMES_W-1:0] frames_granted;
   logic                success;
   logic [LEVEL_W-1:0]  allocated_level, valid_level, unseen_level, free_level;

   spfrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   spfrm_dpath #(
      .MAX_RING_LOG2 (MAX_RING_LOG2)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .ctl             (ctl),
      .cmd             (req_tdata[CMD_W-1:0]),
      .frame_limit     (req_tdata[CMD_W+FRAMES_W-1:CMD_W]),
      .offset          (offset),
      .frames_granted  (frames_granted),
      .success         (success),
      .allocated_level (allocated_level),
      .valid_level     (valid_level),
      .unseen_level    (unseen_level),
      .free_level      (free_level)
   );

   assign rsp_tdata = {2'b00, free_level, unseen_level, valid_level, allocated_level,
                       success, frames_granted, offset};

endmodule
`default_nettype wire
